// ===== sv/shell_command_lexer_defines.svh =====
`ifndef SHELL_COMMAND_LEXER_DEFINES_SVH
`define SHELL_COMMAND_LEXER_DEFINES_SVH

`ifndef ASSERT_OFF
`define SHL_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("assertion failed");
`define SHL_ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("forbidden condition seen");
`else
`define SHL_ASSERT(lbl, clk, rstn, prop)
`define SHL_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ===== sv/shl_pkg.sv =====
package shl_pkg;

	localparam int MAX_RES = 3;

	localparam logic [1:0] MODE_NORMAL  = 2'd0;
	localparam logic [1:0] MODE_SQUOTE  = 2'd1;
	localparam logic [1:0] MODE_DQUOTE  = 2'd2;
	localparam logic [1:0] MODE_COMMENT = 2'd3;

	localparam logic [1:0] RED_NONE = 2'd0;
	localparam logic [1:0] RED_IN   = 2'd1;
	localparam logic [1:0] RED_OUT  = 2'd2;

	localparam logic [2:0] KIND_WORD    = 3'd0;
	localparam logic [2:0] KIND_SQWORD  = 3'd1;
	localparam logic [2:0] KIND_PIPE    = 3'd2;
	localparam logic [2:0] KIND_REDIN   = 3'd3;
	localparam logic [2:0] KIND_REDOUT  = 3'd4;
	localparam logic [2:0] KIND_APPEND  = 3'd5;
	localparam logic [2:0] KIND_HEREDOC = 3'd6;

	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_GT   = 8'h3E;
	localparam logic [7:0] CH_LT   = 8'h3C;
	localparam logic [7:0] CH_PIPE = 8'h7C;
	localparam logic [7:0] CH_SQ   = 8'h27;
	localparam logic [7:0] CH_DQ   = 8'h22;

	typedef struct packed {
		logic [7:0] word_char;
		logic       char_valid;
		logic       token_end;
		logic [2:0] token_kind;
		logic       syntax_error;
		logic       last;
	} res_t;

	typedef struct packed {
		logic [1:0]           cnt;
		res_t [MAX_RES-1:0]   res;
	} bundle_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       word_open;
		logic       word_sq;
		logic [1:0] pend;
		logic       prev_space;
	} lex_state_t;

	localparam lex_state_t ST_RESET = '{
		mode:       MODE_NORMAL,
		word_open:  1'b0,
		word_sq:    1'b0,
		pend:       RED_NONE,
		prev_space: 1'b1
	};

	function automatic res_t chr_res(logic [7:0] c);
		res_t r;
		r = '0;
		r.word_char = c;
		r.char_valid = 1'b1;
		return r;
	endfunction

	function automatic res_t tok_res(logic [2:0] kind);
		res_t r;
		r = '0;
		r.token_end = 1'b1;
		r.token_kind = kind;
		return r;
	endfunction

	function automatic bundle_t put(bundle_t b, res_t r);
		bundle_t o;
		o = b;
		if (b.cnt < 2'(MAX_RES)) begin
			o.res[b.cnt] = r;
			o.cnt = b.cnt + 2'd1;
		end
		return o;
	endfunction

endpackage

// ===== sv/shl_core.sv =====
module shl_core import shl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] in_char,
	input  logic       line_end,
	output bundle_t    bundle
);

	lex_state_t st_q;
	lex_state_t st_d;

	always_comb begin
		logic       do_norm;
		logic       sp;
		logic [7:0] pc;
		logic [7:0] q;
		res_t       err;
		st_d = st_q;
		bundle = '0;
		do_norm = 1'b0;
		sp = (in_char inside {[8'd9:8'd13], 8'd32});
		pc = (st_q.pend == RED_OUT) ? CH_GT : CH_LT;
		q = (st_q.mode == MODE_SQUOTE) ? CH_SQ : CH_DQ;
		err = '0;
		err.syntax_error = 1'b1;

		if (st_q.mode == MODE_NORMAL) begin
			if (st_q.pend != RED_NONE) begin
				st_d.pend = RED_NONE;
				if (in_char == pc) begin
					bundle = put(bundle,
						tok_res((st_q.pend == RED_OUT) ? KIND_APPEND : KIND_HEREDOC));
					st_d.prev_space = 1'b0;
				end else begin
					bundle = put(bundle,
						tok_res((st_q.pend == RED_OUT) ? KIND_REDOUT : KIND_REDIN));
					do_norm = 1'b1;
				end
			end else begin
				do_norm = 1'b1;
			end
		end else if (st_q.mode == MODE_SQUOTE || st_q.mode == MODE_DQUOTE) begin
			if (in_char == q) begin
				st_d.mode = MODE_NORMAL;
			end else begin
				bundle = put(bundle, chr_res(in_char));
			end
			st_d.prev_space = 1'b0;
		end

		if (do_norm) begin
			if (in_char == CH_HASH && st_q.prev_space) begin
				st_d.mode = MODE_COMMENT;
			end else if (sp || in_char == CH_PIPE || in_char == CH_LT || in_char == CH_GT) begin
				if (st_d.word_open) begin
					bundle = put(bundle, tok_res(st_d.word_sq ? KIND_SQWORD : KIND_WORD));
				end
				st_d.word_open = 1'b0;
				st_d.word_sq = 1'b0;
				if (in_char == CH_PIPE) begin
					bundle = put(bundle, tok_res(KIND_PIPE));
				end else if (in_char == CH_LT || in_char == CH_GT) begin
					st_d.pend = (in_char == CH_GT) ? RED_OUT : RED_IN;
				end
			end else if (in_char == CH_SQ) begin
				st_d.word_open = 1'b1;
				st_d.word_sq = 1'b1;
				st_d.mode = MODE_SQUOTE;
			end else if (in_char == CH_DQ) begin
				st_d.word_open = 1'b1;
				st_d.mode = MODE_DQUOTE;
			end else begin
				st_d.word_open = 1'b1;
				bundle = put(bundle, chr_res(in_char));
			end
			st_d.prev_space = sp;
		end

		if (line_end) begin
			if (st_d.mode == MODE_SQUOTE || st_d.mode == MODE_DQUOTE) begin
				bundle = put(bundle, err);
			end else if (st_d.mode == MODE_NORMAL) begin
				if (st_d.pend != RED_NONE) begin
					bundle = put(bundle,
						tok_res((st_d.pend == RED_OUT) ? KIND_REDOUT : KIND_REDIN));
				end
				if (st_d.word_open) begin
					bundle = put(bundle, tok_res(st_d.word_sq ? KIND_SQWORD : KIND_WORD));
				end
			end
			if (bundle.cnt == 2'd0) begin
				bundle = put(bundle, res_t'('0));
			end
			bundle.res[bundle.cnt - 2'd1].last = 1'b1;
			st_d = ST_RESET;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RESET;
		end else if (accept) begin
			st_q <= st_d;
		end
	end

endmodule

// ===== sv/shl_outq.sv =====
module shl_outq import shl_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  bundle_t push_data,
	output logic    ready,
	output logic    out_valid,
	input  logic    out_ready,
	output res_t    out_res
);

	bundle_t    a_q;
	bundle_t    b_q;
	logic       a_valid_q;
	logic       b_valid_q;
	logic [1:0] a_idx_q;
	logic       a_done;
	logic       a_free;

	assign a_done    = a_valid_q && out_ready && (a_idx_q == a_q.cnt - 2'd1);
	assign a_free    = !a_valid_q || a_done;
	assign ready     = !b_valid_q;
	assign out_valid = a_valid_q;
	assign out_res   = a_q.res[a_idx_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_valid_q <= 1'b0;
			b_valid_q <= 1'b0;
			a_idx_q   <= 2'd0;
		end else if (a_free) begin
			a_idx_q <= 2'd0;
			if (b_valid_q) begin
				a_valid_q <= 1'b1;
				b_valid_q <= 1'b0;
			end else begin
				a_valid_q <= push;
			end
		end else begin
			if (out_ready) begin
				a_idx_q <= a_idx_q + 2'd1;
			end
			if (push) begin
				b_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (a_free) begin
			if (b_valid_q) begin
				a_q <= b_q;
			end else if (push) begin
				a_q <= push_data;
			end
		end else if (push) begin
			b_q <= push_data;
		end
	end

endmodule

// ===== sv/shell_command_lexer.sv =====
// The results of a request are registered in the output queue before they are offered.
// One request per cycle while in_ready is high (the second buffer is free); a request
// yields up to 3 results, and two requests' results are buffered.
// Requests that yield no result are accepted with no output.
// Reset (arst_n low): lexer returns to normal mode at line start, buffers empty.
`include "shell_command_lexer_defines.svh"

module shell_command_lexer import shl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_char,
	input  logic       line_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] word_char,
	output logic       char_valid,
	output logic       token_end,
	output logic [2:0] token_kind,
	output logic       syntax_error,
	output logic       last
);

	logic    accept;
	logic    push;
	bundle_t bundle;
	res_t    out_res;

	assign accept = in_valid && in_ready;
	assign push   = accept && (bundle.cnt != 2'd0);

	shl_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.in_char  (in_char),
		.line_end (line_end),
		.bundle   (bundle)
	);

	shl_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (bundle),
		.ready     (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign word_char    = out_res.word_char;
	assign char_valid   = out_res.char_valid;
	assign token_end    = out_res.token_end;
	assign token_kind   = out_res.token_kind;
	assign syntax_error = out_res.syntax_error;
	assign last         = out_res.last;

	`SHL_ASSERT(a_err_is_last, clk, arst_n, (out_valid && syntax_error) |-> last)
	`SHL_ASSERT_NEVER(a_char_and_token, clk, arst_n, out_valid && char_valid && token_end)
	`SHL_ASSERT(a_line_end_result, clk, arst_n, (accept && line_end) |=> out_valid)
	`SHL_ASSERT(a_stall_keeps_out, clk, arst_n, (out_valid && !out_ready) |=> out_valid)

endmodule

// ===== test/tb_shell_command_lexer.sv =====
`timescale 1ns / 100ps

module tb_shell_command_lexer import shl_pkg::*; ();

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 40;

	typedef struct {
		logic [7:0] ch;
		logic       eol;
		int         gap;
		bit         drain;
	} line_byte_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] in_char = 8'h00;
	logic       line_end = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] word_char;
	logic       char_valid;
	logic       token_end;
	logic [2:0] token_kind;
	logic       syntax_error;
	logic       last;

	line_byte_t line_bytes[$];
	res_t       tokens_due[$];
	res_t       step_res[$];
	lex_state_t lx = ST_RESET;

	int  bytes_queued = 0;
	int  chars_taken = 0;
	int  tokens_seen = 0;
	int  mismatches = 0;
	int  cycles = 0;
	int  idle_cnt = 0;
	int  stall_left = 0;
	int  hold_left = 0;
	int  hold_next = 120;
	bit  in_fire = 1'b0;
	bit  out_fire = 1'b0;

	shell_command_lexer u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_char      (in_char),
		.line_end     (line_end),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.word_char    (word_char),
		.char_valid   (char_valid),
		.token_end    (token_end),
		.token_kind   (token_kind),
		.syntax_error (syntax_error),
		.last         (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit is_blank(logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	task automatic queue_result(logic [7:0] c, logic cv, logic te, logic [2:0] kind, logic err);
		res_t r;
		r = '0;
		r.word_char = c;
		r.char_valid = cv;
		r.token_end = te;
		r.token_kind = kind;
		r.syntax_error = err;
		if (step_res.size() < MAX_RES)
			step_res.push_back(r);
	endtask

	task automatic close_word();
		if (lx.word_open)
			queue_result(8'h00, 1'b0, 1'b1, lx.word_sq ? KIND_SQWORD : KIND_WORD, 1'b0);
		lx.word_open = 1'b0;
		lx.word_sq = 1'b0;
	endtask

	task automatic plain_byte(logic [7:0] c);
		if (c == CH_HASH && lx.prev_space) begin
			lx.mode = MODE_COMMENT;
		end else if (is_blank(c)) begin
			close_word();
		end else if (c == CH_PIPE) begin
			close_word();
			queue_result(8'h00, 1'b0, 1'b1, KIND_PIPE, 1'b0);
		end else if (c == CH_LT || c == CH_GT) begin
			close_word();
			lx.pend = (c == CH_GT) ? RED_OUT : RED_IN;
		end else if (c == CH_SQ) begin
			lx.word_open = 1'b1;
			lx.word_sq = 1'b1;
			lx.mode = MODE_SQUOTE;
		end else if (c == CH_DQ) begin
			lx.word_open = 1'b1;
			lx.mode = MODE_DQUOTE;
		end else begin
			lx.word_open = 1'b1;
			queue_result(c, 1'b1, 1'b0, KIND_WORD, 1'b0);
		end
		lx.prev_space = is_blank(c);
	endtask

	task automatic lex_byte(logic [7:0] c, logic eol);
		logic [7:0] pair_ch;
		logic       was_out;
		logic [7:0] quote_ch;
		step_res.delete();
		if (lx.mode == MODE_NORMAL) begin
			if (lx.pend != RED_NONE) begin
				was_out = (lx.pend == RED_OUT);
				pair_ch = was_out ? CH_GT : CH_LT;
				lx.pend = RED_NONE;
				if (c == pair_ch) begin
					queue_result(8'h00, 1'b0, 1'b1, was_out ? KIND_APPEND : KIND_HEREDOC, 1'b0);
					lx.prev_space = 1'b0;
				end else begin
					queue_result(8'h00, 1'b0, 1'b1, was_out ? KIND_REDOUT : KIND_REDIN, 1'b0);
					plain_byte(c);
				end
			end else begin
				plain_byte(c);
			end
		end else if (lx.mode == MODE_SQUOTE || lx.mode == MODE_DQUOTE) begin
			quote_ch = (lx.mode == MODE_SQUOTE) ? CH_SQ : CH_DQ;
			if (c == quote_ch)
				lx.mode = MODE_NORMAL;
			else
				queue_result(c, 1'b1, 1'b0, KIND_WORD, 1'b0);
			lx.prev_space = 1'b0;
		end
		if (eol) begin
			if (lx.mode == MODE_SQUOTE || lx.mode == MODE_DQUOTE) begin
				queue_result(8'h00, 1'b0, 1'b0, KIND_WORD, 1'b1);
			end else if (lx.mode == MODE_NORMAL) begin
				if (lx.pend != RED_NONE)
					queue_result(8'h00, 1'b0, 1'b1,
						(lx.pend == RED_OUT) ? KIND_REDOUT : KIND_REDIN, 1'b0);
				close_word();
			end
			if (step_res.size() == 0)
				queue_result(8'h00, 1'b0, 1'b0, KIND_WORD, 1'b0);
			step_res[step_res.size() - 1].last = 1'b1;
			lx = ST_RESET;
		end
		foreach (step_res[i])
			tokens_due.push_back(step_res[i]);
	endtask

	task automatic push_byte(logic [7:0] ch, logic eol, bit drain = 1'b0);
		line_byte_t b;
		b.ch = ch;
		b.eol = eol;
		b.drain = drain;
		b.gap = ((bytes_queued / 60) % 3 == 2) ? 0 : $urandom_range(0, 4);
		line_bytes.push_back(b);
		bytes_queued++;
	endtask

	task automatic push_line(string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i], i == s.len() - 1);
	endtask

	task automatic push_random_line(bit drain);
		logic [7:0] text[$];
		logic [7:0] q;
		int         n;
		int         k;
		repeat ($urandom_range(1, 8)) begin
			case ($urandom_range(0, 11))
				0, 1, 2, 3: begin
					n = $urandom_range(1, 4);
					repeat (n) text.push_back(8'($urandom_range(8'h61, 8'h7A)));
				end
				4, 5: begin
					k = $urandom_range(8, 13);
					text.push_back(k == 8 ? 8'h20 : 8'(k));
				end
				6, 7: begin
					case ($urandom_range(0, 4))
						0: text.push_back(CH_PIPE);
						1: text.push_back(CH_LT);
						2: text.push_back(CH_GT);
						3: begin
							text.push_back(CH_LT);
							text.push_back(CH_LT);
						end
						default: begin
							text.push_back(CH_GT);
							text.push_back(CH_GT);
						end
					endcase
				end
				8, 9: begin
					q = $urandom_range(0, 1) ? CH_SQ : CH_DQ;
					text.push_back(q);
					n = $urandom_range(0, 3);
					repeat (n) begin
						case ($urandom_range(0, 3))
							0: text.push_back(8'($urandom_range(8'h61, 8'h7A)));
							1: text.push_back(8'h20);
							2: begin
								k = $urandom_range(0, 255);
								text.push_back(8'(k) == q ? 8'h41 : 8'(k));
							end
							default: begin
								case ($urandom_range(0, 4))
									0: text.push_back(CH_HASH);
									1: text.push_back(CH_PIPE);
									2: text.push_back(CH_LT);
									3: text.push_back(CH_GT);
									default: text.push_back(q == CH_SQ ? CH_DQ : CH_SQ);
								endcase
							end
						endcase
					end
					if ($urandom_range(0, 7) != 0)
						text.push_back(q);
				end
				10: text.push_back(CH_HASH);
				default: text.push_back(8'($urandom_range(0, 255)));
			endcase
		end
		foreach (text[i])
			push_byte(text[i], i == text.size() - 1, drain && i == 0);
	endtask

	task automatic report(string what, res_t want, res_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$write("%s at result %0d: want char=%h cv=%b end=%b kind=%0d err=%b last=%b,",
				what, tokens_seen, want.word_char, want.char_valid, want.token_end,
				want.token_kind, want.syntax_error, want.last);
			$display(" got char=%h cv=%b end=%b kind=%0d err=%b last=%b",
				got.word_char, got.char_valid, got.token_end, got.token_kind,
				got.syntax_error, got.last);
		end
	endtask

	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (!arst_n) begin
			in_fire = 1'b0;
			out_fire = 1'b0;
		end else begin
			in_fire = in_valid && in_ready;
			out_fire = out_valid && out_ready;
			if (in_fire) begin
				lex_byte(in_char, line_end);
				chars_taken++;
			end
			if (out_fire) begin
				got = {word_char, char_valid, token_end, token_kind, syntax_error, last};
				if (tokens_due.size() == 0) begin
					report("unexpected result", '0, got);
				end else begin
					want = tokens_due.pop_front();
					if (got !== want)
						report("mismatch", want, got);
				end
				tokens_seen++;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n && !(in_valid && !in_fire)) begin
			if (line_bytes.size() != 0 && idle_cnt < line_bytes[0].gap) begin
				idle_cnt <= idle_cnt + 1;
				in_valid <= 1'b0;
			end else if (line_bytes.size() != 0
					&& !(line_bytes[0].drain && tokens_due.size() != 0)) begin
				in_valid <= 1'b1;
				in_char <= line_bytes[0].ch;
				line_end <= line_bytes[0].eol;
				line_bytes.pop_front();
				idle_cnt <= 0;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (chars_taken >= hold_next) begin
				hold_left <= HOLD_CYCLES;
				hold_next <= hold_next + 200;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (out_fire)
				stall_left = ((tokens_seen / 80) % 3 == 1) ? 0 : $urandom_range(0, 4);
			if (stall_left != 0) begin
				stall_left = stall_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= (hold_left == 0);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int line_no;
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_line(">>a");
		push_line("<<''|");
		push_line("'x y");
		push_line("a#\t#");
		push_line("\"<\"");
		push_line("<>");
		push_line("#x");
		line_no = 0;
		while (bytes_queued < 475) begin
			push_random_line(line_no % 6 == 0);
			line_no++;
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (chars_taken < bytes_queued || tokens_due.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);

		if (mismatches == 0 && tokens_due.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== shell_command_lexer.f =====
+incdir+sv
sv/shl_pkg.sv
sv/shl_core.sv
sv/shl_outq.sv
sv/shell_command_lexer.sv
test/tb_shell_command_lexer.sv
